### src/mdhk_pkg.sv
// Shared types, sizes and codes for the multi-device held-key tracker.
package mdhk_pkg;

    localparam int MAX_KEYS    = 32;
    localparam int MAX_DEVICES = 32;
    localparam int OWNER_W     = 32;
    localparam int SLOT_LIMIT  = (MAX_DEVICES < OWNER_W) ? MAX_DEVICES : OWNER_W;
    localparam int KEY_W       = 10;
    localparam int DEV_W       = 5;
    localparam int IDX_W       = $clog2(MAX_KEYS);
    localparam int CNT_W       = $clog2(MAX_KEYS + 1);
    localparam int ENTRY_W     = KEY_W + OWNER_W;

    typedef enum logic [1:0] {
        CMD_ATTACH = 2'd0,
        CMD_DETACH = 2'd1,
        CMD_KEY    = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FILTERED = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_OR,
        WR_ANDN,
        WR_APPEND,
        WR_MOVE
    } wr_kind_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_LAST
    } rd_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_LAST,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic     capture;
        logic     attach_do;
        logic     detach_clr;
        rd_sel_t  rd_sel;
        idx_op_t  idx_op;
        logic     tgt_load;
        wr_kind_t wr_kind;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_we;
        status_t  res_status;
        logic     held_set;
        logic     out_load;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic pressed;
        logic dev_ok;
        logic cnt_zero;
        logic full;
        logic hit;
        logic at_last;
        logic sole;
        logic idx_zero;
    } stat_t;

endpackage

### src/mdhk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mdhk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/mdhk_datapath.sv
// Datapath of the held-key tracker: item registers, key table, counters and results.
module mdhk_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            command,
    input  logic [4:0]            device,
    input  logic [9:0]            key,
    input  logic                  pressed,
    input  mdhk_pkg::ctrl_t       ctl,
    output mdhk_pkg::stat_t       stat,
    output logic [1:0]            status,
    output logic [4:0]            assigned_device,
    output logic                  key_held
);

    logic [1:0]                      cmd_reg;
    logic [mdhk_pkg::DEV_W-1:0]      device_reg;
    logic [mdhk_pkg::KEY_W-1:0]      key_reg;
    logic                            pressed_reg;
    logic [mdhk_pkg::IDX_W-1:0]      idx_reg;
    logic [mdhk_pkg::IDX_W-1:0]      rd_idx_reg;
    logic [mdhk_pkg::IDX_W-1:0]      tgt_reg;
    logic [mdhk_pkg::CNT_W-1:0]      count_reg;
    logic [mdhk_pkg::OWNER_W-1:0]    in_use_reg;
    mdhk_pkg::status_t               res_status_reg;
    logic [mdhk_pkg::DEV_W-1:0]      res_assigned_reg;
    logic                            res_held_reg;
    mdhk_pkg::status_t               out_status_reg;
    logic [mdhk_pkg::DEV_W-1:0]      out_assigned_reg;
    logic                            out_held_reg;

    logic                            dev_ok;
    logic [mdhk_pkg::OWNER_W-1:0]    dev_bit;
    logic [mdhk_pkg::CNT_W-1:0]      cnt_minus1;
    logic [mdhk_pkg::IDX_W-1:0]      last_idx;
    logic                            free_found;
    logic [mdhk_pkg::DEV_W-1:0]      free_slot;
    logic                            ram_we;
    logic [mdhk_pkg::IDX_W-1:0]      ram_waddr;
    logic [mdhk_pkg::ENTRY_W-1:0]    ram_wdata;
    logic                            ram_re;
    logic [mdhk_pkg::IDX_W-1:0]      ram_raddr;
    logic [mdhk_pkg::ENTRY_W-1:0]    ram_rdata;
    logic [mdhk_pkg::KEY_W-1:0]      rd_key;
    logic [mdhk_pkg::OWNER_W-1:0]    rd_owners;

    assign dev_ok     = (32'(device_reg) < 32'(mdhk_pkg::MAX_DEVICES));
    assign dev_bit    = dev_ok ? (mdhk_pkg::OWNER_W'(1) << device_reg) : '0;
    assign cnt_minus1 = count_reg - mdhk_pkg::CNT_W'(1);
    assign last_idx   = cnt_minus1[mdhk_pkg::IDX_W-1:0];
    assign rd_key     = ram_rdata[mdhk_pkg::ENTRY_W-1:mdhk_pkg::OWNER_W];
    assign rd_owners  = ram_rdata[mdhk_pkg::OWNER_W-1:0];

    // The lowest free device slot is picked by a priority encoder.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = mdhk_pkg::SLOT_LIMIT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = mdhk_pkg::DEV_W'(i);
            end
        end
    end

    always_comb
    begin
        ram_re    = (ctl.rd_sel != mdhk_pkg::RD_NONE);
        ram_raddr = (ctl.rd_sel == mdhk_pkg::RD_LAST) ? last_idx : idx_reg;
        ram_we    = (ctl.wr_kind != mdhk_pkg::WR_NONE);
        ram_waddr = rd_idx_reg;
        ram_wdata = ram_rdata;
        case (ctl.wr_kind)
            mdhk_pkg::WR_OR:
            begin
                ram_wdata = {rd_key, rd_owners | dev_bit};
            end
            mdhk_pkg::WR_ANDN:
            begin
                ram_wdata = {rd_key, rd_owners & ~dev_bit};
            end
            mdhk_pkg::WR_APPEND:
            begin
                ram_waddr = count_reg[mdhk_pkg::IDX_W-1:0];
                ram_wdata = {key_reg, dev_bit};
            end
            mdhk_pkg::WR_MOVE:
            begin
                ram_waddr = tgt_reg;
            end
            default:
            begin
                ram_wdata = ram_rdata;
            end
        endcase
    end

    mdhk_ram #(
        .WIDTH (mdhk_pkg::ENTRY_W),
        .DEPTH (mdhk_pkg::MAX_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            in_use_reg <= '0;
        end
        else
        begin
            if (ctl.cnt_inc)
            begin
                count_reg <= count_reg + mdhk_pkg::CNT_W'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= cnt_minus1;
            end
            if (ctl.attach_do && free_found)
            begin
                in_use_reg <= in_use_reg | (mdhk_pkg::OWNER_W'(1) << free_slot);
            end
            else if (ctl.detach_clr)
            begin
                in_use_reg <= in_use_reg & ~dev_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg          <= command;
            device_reg       <= device;
            key_reg          <= key;
            pressed_reg      <= pressed;
            res_status_reg   <= mdhk_pkg::ST_OK;
            res_assigned_reg <= '0;
            res_held_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.attach_do)
            begin
                if (free_found)
                begin
                    res_assigned_reg <= free_slot;
                end
                else
                begin
                    res_status_reg <= mdhk_pkg::ST_NO_SLOT;
                end
            end
            if (ctl.res_we)
            begin
                res_status_reg <= ctl.res_status;
            end
            if (ctl.held_set)
            begin
                res_held_reg <= 1'b1;
            end
        end
        case (ctl.idx_op)
            mdhk_pkg::IDX_ZERO: idx_reg <= '0;
            mdhk_pkg::IDX_LAST: idx_reg <= last_idx;
            mdhk_pkg::IDX_INC:  idx_reg <= idx_reg + mdhk_pkg::IDX_W'(1);
            mdhk_pkg::IDX_DEC:  idx_reg <= idx_reg - mdhk_pkg::IDX_W'(1);
            default:            idx_reg <= idx_reg;
        endcase
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
        if (ctl.tgt_load)
        begin
            tgt_reg <= rd_idx_reg;
        end
        if (ctl.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_assigned_reg <= res_assigned_reg;
            out_held_reg     <= res_held_reg;
        end
    end

    always_comb
    begin
        stat.cmd      = mdhk_pkg::cmd_t'(cmd_reg);
        stat.pressed  = pressed_reg;
        stat.dev_ok   = dev_ok;
        stat.cnt_zero = (count_reg == '0);
        stat.full     = (count_reg == mdhk_pkg::CNT_W'(mdhk_pkg::MAX_KEYS));
        stat.hit      = (rd_key == key_reg);
        stat.at_last  = (rd_idx_reg == last_idx);
        stat.sole     = (rd_owners == dev_bit);
        stat.idx_zero = (idx_reg == '0);
    end

    assign status          = out_status_reg;
    assign assigned_device = out_assigned_reg;
    assign key_held        = out_held_reg;

endmodule

### src/mdhk_ctrl.sv
// Controller state machine that sequences the table search, update and compaction.
module mdhk_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  mdhk_pkg::stat_t stat,
    output mdhk_pkg::ctrl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_MISS,
        S_DRD,
        S_DCHK,
        S_MOVE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    ctl.idx_op  = mdhk_pkg::IDX_ZERO;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                case (stat.cmd)
                    mdhk_pkg::CMD_ATTACH:
                    begin
                        ctl.attach_do = 1'b1;
                        state_next    = S_DONE;
                    end
                    mdhk_pkg::CMD_DETACH:
                    begin
                        if (!stat.dev_ok)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.detach_clr = 1'b1;
                            ctl.idx_op     = mdhk_pkg::IDX_LAST;
                            state_next     = stat.cnt_zero ? S_DONE : S_DRD;
                        end
                    end
                    mdhk_pkg::CMD_KEY:
                    begin
                        if (!stat.dev_ok)
                        begin
                            ctl.res_we     = 1'b1;
                            ctl.res_status = mdhk_pkg::ST_FILTERED;
                            state_next     = S_DONE;
                        end
                        else if (stat.cnt_zero)
                        begin
                            state_next = S_MISS;
                        end
                        else
                        begin
                            ctl.rd_sel = mdhk_pkg::RD_IDX;
                            ctl.idx_op = mdhk_pkg::IDX_INC;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        if (stat.cnt_zero)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.rd_sel = mdhk_pkg::RD_IDX;
                            ctl.idx_op = mdhk_pkg::IDX_INC;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    if (stat.cmd == mdhk_pkg::CMD_QUERY)
                    begin
                        ctl.held_set = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (stat.pressed)
                    begin
                        ctl.wr_kind    = mdhk_pkg::WR_OR;
                        ctl.res_we     = 1'b1;
                        ctl.res_status = mdhk_pkg::ST_FILTERED;
                        state_next     = S_DONE;
                    end
                    else if (stat.sole)
                    begin
                        ctl.rd_sel   = mdhk_pkg::RD_LAST;
                        ctl.tgt_load = 1'b1;
                        state_next   = S_MOVE;
                    end
                    else
                    begin
                        ctl.wr_kind    = mdhk_pkg::WR_ANDN;
                        ctl.res_we     = 1'b1;
                        ctl.res_status = mdhk_pkg::ST_FILTERED;
                        state_next     = S_DONE;
                    end
                end
                else if (stat.at_last)
                begin
                    state_next = (stat.cmd == mdhk_pkg::CMD_QUERY) ? S_DONE : S_MISS;
                end
                else
                begin
                    ctl.rd_sel = mdhk_pkg::RD_IDX;
                    ctl.idx_op = mdhk_pkg::IDX_INC;
                end
            end
            S_MISS:
            begin
                if (!stat.pressed)
                begin
                    ctl.res_we     = 1'b1;
                    ctl.res_status = mdhk_pkg::ST_FILTERED;
                end
                else if (stat.full)
                begin
                    ctl.res_we     = 1'b1;
                    ctl.res_status = mdhk_pkg::ST_FULL;
                end
                else
                begin
                    ctl.wr_kind = mdhk_pkg::WR_APPEND;
                    ctl.cnt_inc = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DRD:
            begin
                ctl.rd_sel = mdhk_pkg::RD_IDX;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (stat.sole)
                begin
                    ctl.rd_sel   = mdhk_pkg::RD_LAST;
                    ctl.tgt_load = 1'b1;
                    state_next   = S_MOVE;
                end
                else
                begin
                    ctl.wr_kind = mdhk_pkg::WR_ANDN;
                    if (stat.idx_zero)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.idx_op = mdhk_pkg::IDX_DEC;
                        state_next = S_DRD;
                    end
                end
            end
            S_MOVE:
            begin
                ctl.wr_kind = mdhk_pkg::WR_MOVE;
                ctl.cnt_dec = 1'b1;
                if (stat.cmd == mdhk_pkg::CMD_DETACH && !stat.idx_zero)
                begin
                    ctl.idx_op = mdhk_pkg::IDX_DEC;
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = ctl.out_load | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/multi_device_held_key_tracker.sv
// Top level of the multi-device held-key tracker.
//
// The input channel (in_valid, in_stall) carries one command item: attach,
// detach, key event or query, with its device, key and pressed fields. The
// output channel (out_valid, out_stall) returns exactly one result item for
// each input item: status, assigned_device and key_held, in input order.
// One item is processed at a time; in_stall is high from acceptance until
// the result is loaded into the output register, and the next item may be
// accepted while that result still waits to be taken.
// Attach completes without a table search. Query and key event search the
// held entries one entry per cycle through the key table RAM read port;
// detach reads and checks each entry and, if it is removed, replaces it
// by the last entry through the same single read port.
// Reset empties the table and detaches every device at once; no clearing
// pass is needed. While out_stall holds a result, a finished next result
// waits inside the block and no further item is accepted.
module multi_device_held_key_tracker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [4:0] device,
    input  logic [9:0] key,
    input  logic       pressed,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [4:0] assigned_device,
    output logic       key_held
);

    mdhk_pkg::ctrl_t ctl;
    mdhk_pkg::stat_t stat;

    mdhk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    mdhk_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .device          (device),
        .key             (key),
        .pressed         (pressed),
        .ctl             (ctl),
        .stat            (stat),
        .status          (status),
        .assigned_device (assigned_device),
        .key_held        (key_held)
    );

endmodule
